// ===== rtl/core/ultrasonic_range_controller_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Ultrasonic range controller assertion macros
// Shared concurrent assertion forms for the range controller checkers.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_RANGE_CONTROLLER_UNIT_MACROS_SVH
`define ULTRASONIC_RANGE_CONTROLLER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define URC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define URC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/urc_pkg.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic range controller package
// Shared types, widths, reset values and helper functions.
// ----------------------------------------------------------------------------
package urc_pkg;

    // Width of the microsecond phase and echo counter.
    localparam int TIMER_BITS = 16;
    localparam int CNT_W      = TIMER_BITS;

    // Configuration and result field widths.
    localparam int CFG_W      = 16;
    localparam int WIDTH_W    = 16;
    localparam int DIST_W     = 24;
    localparam int CFG_IDX_W  = 2;

    // Stream widths.
    localparam int S_TDATA_W  = 8;
    localparam int M_FIELD_W  = 4 + WIDTH_W + DIST_W;
    localparam int M_TDATA_W  = ((M_FIELD_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELD_W;

    // Speed of sound in micrometres per microsecond, doubled path.
    localparam int SOUND_UM   = 343;
    localparam int PROD_W     = WIDTH_W + 9;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd2;

    // Configuration reset values.
    localparam logic [CFG_W-1:0] TRIG_LOW_RST  = 16'd3;
    localparam logic [CFG_W-1:0] TRIG_HIGH_RST = 16'd10;
    localparam logic [CFG_W-1:0] TIMEOUT_RST   = 16'd65000;

    // Limit capping: the timer cannot hold more than its all-ones value.
    localparam int CAP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam logic [CAP_W-1:0] TIMER_MAX = {CAP_W{1'b1}} >> (CAP_W - TIMER_BITS);

    // Measurement phases.
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_LOW  = 3'd1,
        PH_HIGH = 3'd2,
        PH_WAIT = 3'd3,
        PH_MEAS = 3'd4
    } phase_t;

    // Caps a configured limit to the timer range.
    function automatic logic [CNT_W-1:0] cap_limit(input logic [CFG_W-1:0] v);
        logic [CAP_W-1:0] v_ext;
        logic [CAP_W-1:0] r;
        v_ext = CAP_W'(v);
        r     = (v_ext > TIMER_MAX) ? TIMER_MAX : v_ext;
        return CNT_W'(r);
    endfunction

    // A zero limit acts as one.
    function automatic logic [CFG_W-1:0] at_least_one(input logic [CFG_W-1:0] v);
        return (v == '0) ? CFG_W'(1) : v;
    endfunction

endpackage

// ===== rtl/core/ultrasonic_range_controller_unit.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic range controller
// Trigger pulse generator and echo timer, one microsecond tick per transaction.
// ----------------------------------------------------------------------------
// Channel  | Direction | Contents
// s_axis   | in        | tdata[0] start_req, tdata[1] echo
// m_axis   | out       | trigger, busy, done, timeout, echo width, distance
// cfg      | in        | cfg_index selects trig_low, trig_high or timeout
//
// One tick transaction is taken per clock; its result is ready in the next cycle.
// The state update and the 16 x 9 distance product sit between the state
// registers and the result register, so nothing limits the rate but m_tready.
// A held result stalls input only while m_tready is low.
// aresetn is synchronous and active low; configuration returns to 3, 10, 65000.
// ----------------------------------------------------------------------------
module ultrasonic_range_controller_unit
    import urc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Tick input: [0] start_req, [1] echo, [7:2] zero
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // Result: [0] trigger, [1] busy_res, [2] done_res, [3] timed_out,
    // [19:4] echo_width_us, [43:20] distance_um, [47:44] zero
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    // Configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    logic [CFG_W-1:0]   trig_low_reg;
    logic [CFG_W-1:0]   trig_high_reg;
    logic [CFG_W-1:0]   timeout_reg;

    phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               echo_last_reg;
    logic [WIDTH_W-1:0] width_reg, width_next;
    logic [DIST_W-1:0]  dist_reg, dist_next;
    logic               tmo_reg, tmo_next;
    logic               done_next;

    logic               m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic               s_accept;
    logic               start_req;
    logic               echo;
    logic               rise;
    logic [CNT_W-1:0]   lo_lim, hi_lim, to_lim;
    logic [WIDTH_W-1:0] fin_width;
    logic [PROD_W-1:0]  prod;

    assign start_req = s_tdata[0];
    assign echo      = s_tdata[1];
    assign rise      = echo & ~echo_last_reg;

    // The result register parts the two sides; it is refilled as it drains.
    assign s_tready  = ~m_tvalid_reg | m_tready;
    assign s_accept  = s_tvalid & s_tready;
    assign cfg_ready = 1'b1;

    assign lo_lim = cap_limit(trig_low_reg);
    assign hi_lim = cap_limit(at_least_one(trig_high_reg));
    assign to_lim = cap_limit(at_least_one(timeout_reg));

    // Width reported on completion and its round-trip path in micrometres.
    assign fin_width = WIDTH_W'(count_reg);
    assign prod      = PROD_W'(fin_width) * PROD_W'(SOUND_UM);

    // Configuration registers; writes to unused indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trig_low_reg  <= TRIG_LOW_RST;
            trig_high_reg <= TRIG_HIGH_RST;
            timeout_reg   <= TIMEOUT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_TRIG_LOW:  trig_low_reg  <= cfg_data;
                CFG_TRIG_HIGH: trig_high_reg <= cfg_data;
                CFG_TIMEOUT:   timeout_reg   <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Next phase, counter and held measurement for one tick.
    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        width_next = width_reg;
        dist_next  = dist_reg;
        tmo_next   = tmo_reg;
        done_next  = 1'b0;
        case (phase_reg)
            PH_IDLE: begin
                if (start_req) begin
                    phase_next = (lo_lim == '0) ? PH_HIGH : PH_LOW;
                    count_next = CNT_W'(1);
                end
            end
            PH_LOW: begin
                if (count_reg >= lo_lim) begin
                    phase_next = PH_HIGH;
                    count_next = CNT_W'(1);
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end
            PH_HIGH: begin
                if (count_reg >= hi_lim) begin
                    phase_next = PH_WAIT;
                    count_next = '0;
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end
            PH_WAIT: begin
                if (rise) begin
                    phase_next = PH_MEAS;
                    count_next = CNT_W'(1);
                end
            end
            PH_MEAS: begin
                if (!echo || (count_reg >= to_lim)) begin
                    phase_next = PH_IDLE;
                    count_next = '0;
                    width_next = fin_width;
                    dist_next  = prod[DIST_W:1];
                    tmo_next   = echo;
                    done_next  = 1'b1;
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end
            default: begin
                phase_next = PH_IDLE;
                count_next = '0;
            end
        endcase
    end

    // State update on each accepted tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            echo_last_reg <= 1'b0;
            width_reg     <= '0;
            dist_reg      <= '0;
            tmo_reg       <= 1'b0;
        end else if (s_accept) begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            echo_last_reg <= echo;
            width_reg     <= width_next;
            dist_reg      <= dist_next;
            tmo_reg       <= tmo_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Result payload, showing the state after the tick.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= {{M_PAD_W{1'b0}}, dist_next, width_next, tmo_next, done_next,
                            (phase_next != PH_IDLE), (phase_next == PH_HIGH)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== rtl/core/urc_checker.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic range controller checker
// Port-level assertions, bound to the range controller top level.
// ----------------------------------------------------------------------------
`include "ultrasonic_range_controller_unit_macros.svh"

module urc_checker
    import urc_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic [CFG_W-1:0]     cfg_data
);

    logic unused_inputs;
    assign unused_inputs = ^{s_tdata, cfg_valid, cfg_ready, cfg_index, cfg_data};

    // A stalled result must hold its payload.
    `URC_ASSERT_NEXT(a_result_held, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "result changed while stalled")

    // Every accepted tick produces a result in the next cycle.
    `URC_ASSERT_NEXT(a_tick_result, aclk, aresetn, s_tvalid && s_tready,
        m_tvalid, "accepted tick produced no result")

    // The completion tick already shows the block idle.
    `URC_ASSERT_NOW(a_done_idle, aclk, aresetn, m_tvalid && m_tdata[2],
        !m_tdata[1] && !m_tdata[0], "completion shown while busy")

    // The trigger is only driven during a measurement.
    `URC_ASSERT_NOW(a_trig_busy, aclk, aresetn, m_tvalid && m_tdata[0],
        m_tdata[1], "trigger high while idle")

endmodule

bind ultrasonic_range_controller_unit urc_checker u_urc_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic range controller testbench
// Feeds microsecond tick transactions (start request and echo level) into the
// controller, predicts every result transaction with a cycle-free model of the
// trigger and echo timer, and compares them field by field in arrival order.
// Configuration is reprogrammed between phases once the block has drained.
// ----------------------------------------------------------------------------
module tb_top;
    import urc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;
    localparam int SOUND_SPEED_UM = 343;
    localparam int PHASE_TICKS    = 280;

    // One expected result transaction.
    typedef struct packed {
        logic               trigger;
        logic               busy;
        logic               done;
        logic               timed_out;
        logic [WIDTH_W-1:0] width_us;
        logic [DIST_W-1:0]  distance_um;
    } reading_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // Stimulus and expectation stores.
    logic [S_TDATA_W-1:0] pending_ticks[$];
    reading_t             expected_readings[$];
    bit                   tick_in_flight = 1'b0;
    int                   ticks_queued   = 0;
    int                   fail_count     = 0;
    int                   src_pct        = 0;
    int                   sink_pct       = 0;
    int                   src_gap        = 0;
    int                   sink_gap       = 0;
    int                   idle_cycles    = 0;

    // Shadow of the configuration registers.
    logic [CFG_W-1:0] shadow_low     = TRIG_LOW_RST;
    logic [CFG_W-1:0] shadow_high    = TRIG_HIGH_RST;
    logic [CFG_W-1:0] shadow_timeout = TIMEOUT_RST;

    // Predicted controller state.
    phase_t            pred_phase    = PH_IDLE;
    logic [CNT_W-1:0]  pred_count    = '0;
    logic              pred_echo_q   = 1'b0;
    logic [WIDTH_W-1:0] pred_width   = '0;
    logic [DIST_W-1:0] pred_distance = '0;
    logic              pred_timeout  = 1'b0;

    ultrasonic_range_controller_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock generation.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // A limit cannot exceed what the phase timer holds.
    function automatic logic [CNT_W-1:0] timer_limit(input logic [CFG_W-1:0] v);
        logic [31:0] wide;
        wide = 32'(v);
        return (wide > 32'(TIMER_MAX)) ? CNT_W'(TIMER_MAX) : CNT_W'(wide);
    endfunction

    // Advances the predicted controller by one tick and queues its result.
    task automatic predict_tick(input logic start, input logic echo);
        logic [CNT_W-1:0] lim_low;
        logic [CNT_W-1:0] lim_high;
        logic [CNT_W-1:0] lim_timeout;
        logic             rise;
        logic             done;
        reading_t         r;
        lim_low     = timer_limit(shadow_low);
        lim_high    = timer_limit((shadow_high == '0) ? CFG_W'(1) : shadow_high);
        lim_timeout = timer_limit((shadow_timeout == '0) ? CFG_W'(1) : shadow_timeout);
        rise        = echo && !pred_echo_q;
        done        = 1'b0;
        case (pred_phase)
            PH_IDLE: begin
                if (start) begin
                    pred_phase = (lim_low == '0) ? PH_HIGH : PH_LOW;
                    pred_count = CNT_W'(1);
                end
            end
            PH_LOW: begin
                if (pred_count >= lim_low) begin
                    pred_phase = PH_HIGH;
                    pred_count = CNT_W'(1);
                end else begin
                    pred_count = pred_count + 1'b1;
                end
            end
            PH_HIGH: begin
                if (pred_count >= lim_high) begin
                    pred_phase = PH_WAIT;
                    pred_count = '0;
                end else begin
                    pred_count = pred_count + 1'b1;
                end
            end
            PH_WAIT: begin
                if (rise) begin
                    pred_phase = PH_MEAS;
                    pred_count = CNT_W'(1);
                end
            end
            PH_MEAS: begin
                // A falling edge ends normally; echo still high at the limit is a timeout.
                if (!echo || pred_count >= lim_timeout) begin
                    pred_width    = WIDTH_W'(pred_count);
                    pred_distance = DIST_W'((32'(pred_count) * SOUND_SPEED_UM) / 2);
                    pred_timeout  = echo;
                    pred_phase    = PH_IDLE;
                    pred_count    = '0;
                    done          = 1'b1;
                end else begin
                    pred_count = pred_count + 1'b1;
                end
            end
            default: begin
                pred_phase = PH_IDLE;
                pred_count = '0;
            end
        endcase
        pred_echo_q   = echo;
        r.trigger     = (pred_phase == PH_HIGH);
        r.busy        = (pred_phase != PH_IDLE);
        r.done        = done;
        r.timed_out   = pred_timeout;
        r.width_us    = pred_width;
        r.distance_um = pred_distance;
        expected_readings.push_back(r);
    endtask

    task automatic flag_error(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
    endtask

    // Tick driver: presents queued ticks with random idle bursts.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid       <= 1'b0;
            s_tdata        <= '0;
            src_gap        = 0;
            tick_in_flight = 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_tick(s_tdata[0], s_tdata[1]);
                tick_in_flight = 1'b0;
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (src_pct != 0 && $urandom_range(99) < src_pct) begin
                    src_gap  = $urandom_range(0, 9);
                    s_tvalid <= 1'b0;
                end else if (pending_ticks.size() != 0) begin
                    s_tdata        <= pending_ticks.pop_front();
                    s_tvalid       <= 1'b1;
                    tick_in_flight = 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: stalls at random and checks each result transaction.
    always @(posedge aclk) begin
        reading_t want;
        reading_t got;
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.trigger     = m_tdata[0];
                got.busy        = m_tdata[1];
                got.done        = m_tdata[2];
                got.timed_out   = m_tdata[3];
                got.width_us    = m_tdata[4 +: WIDTH_W];
                got.distance_um = m_tdata[4 + WIDTH_W +: DIST_W];
                if (expected_readings.size() == 0) begin
                    flag_error("result transaction with no tick awaiting it");
                end else begin
                    want = expected_readings.pop_front();
                    if (got.trigger !== want.trigger || got.busy !== want.busy ||
                        got.done !== want.done || got.timed_out !== want.timed_out ||
                        got.width_us !== want.width_us ||
                        got.distance_um !== want.distance_um) begin
                        flag_error($sformatf({"result mismatch: expected trig %0b busy %0b ",
                            "done %0b tmo %0b width %0d dist %0d, got trig %0b busy %0b ",
                            "done %0b tmo %0b width %0d dist %0d"},
                            want.trigger, want.busy, want.done, want.timed_out,
                            want.width_us, want.distance_um, got.trigger, got.busy,
                            got.done, got.timed_out, got.width_us, got.distance_um));
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else if (sink_pct != 0 && $urandom_range(99) < sink_pct) begin
                sink_gap = $urandom_range(0, 9);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic queue_tick(input logic start, input logic echo);
        pending_ticks.push_back({{(S_TDATA_W-2){1'b0}}, echo, start});
        ticks_queued++;
    endtask

    // Waits until every tick has been taken and every result has arrived.
    task automatic wait_drained();
        do begin
            @(posedge aclk);
        end while (pending_ticks.size() != 0 || tick_in_flight ||
                   expected_readings.size() != 0);
        @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_TRIG_LOW:  shadow_low     = val;
            CFG_TRIG_HIGH: shadow_high    = val;
            CFG_TIMEOUT:   shadow_timeout = val;
            default: ;
        endcase
    endtask

    task automatic program_ranger(input int low_us, input int high_us, input int limit_us);
        write_reg(CFG_TRIG_LOW, CFG_W'(low_us));
        write_reg(CFG_TRIG_HIGH, CFG_W'(high_us));
        write_reg(CFG_TIMEOUT, CFG_W'(limit_us));
    endtask

    // Drains, then pulses echo until the measurement in progress is over.
    task automatic settle_to_idle();
        wait_drained();
        while (pred_phase != PH_IDLE) begin
            queue_tick(1'b0, 1'b0);
            queue_tick(1'b0, 1'b1);
            queue_tick(1'b0, 1'b0);
            wait_drained();
        end
    endtask

    // Mostly complete measurements with random timing, the rest random noise.
    task automatic queue_random_ticks(input int count);
        int unsigned lo_eff;
        int unsigned hi_eff;
        int unsigned to_eff;
        int unsigned trig_ticks;
        int unsigned pulse;
        bit          stale;
        int          goal;
        goal   = ticks_queued + count;
        lo_eff = 32'(shadow_low);
        hi_eff = (shadow_high == '0) ? 32'd1 : 32'(shadow_high);
        to_eff = (shadow_timeout == '0) ? 32'd1 : 32'(shadow_timeout);
        while (ticks_queued < goal) begin
            if ($urandom_range(99) < 80) begin
                stale      = ($urandom_range(5) == 0);
                trig_ticks = lo_eff + hi_eff;
                queue_tick(1'b1, 1'b0);
                // Start requests during the trigger phases must be ignored.
                for (int unsigned i = 0; i < trig_ticks; i++) begin
                    queue_tick(1'($urandom_range(1)), stale && (i + 2 >= trig_ticks));
                end
                // An echo already high when waiting begins must not count.
                if (stale) begin
                    repeat ($urandom_range(1, 3)) queue_tick(1'($urandom_range(1)), 1'b1);
                    repeat ($urandom_range(1, 2)) queue_tick(1'($urandom_range(1)), 1'b0);
                end
                repeat ($urandom_range(0, 4)) queue_tick(1'($urandom_range(1)), 1'b0);
                pulse = (to_eff < 40) ? $urandom_range(1, to_eff + 2) : $urandom_range(1, 40);
                for (int unsigned i = 0; i < pulse; i++) begin
                    queue_tick((i < to_eff) ? 1'($urandom_range(1)) : 1'b0, 1'b1);
                end
                queue_tick(1'b0, 1'b0);
                repeat ($urandom_range(0, 3)) queue_tick(1'b0, 1'b0);
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    queue_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
                end
            end
        end
    endtask

    // Test sequence.
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset configuration with light idling on both sides.
        src_pct  = 10;
        sink_pct = 10;
        queue_random_ticks(PHASE_TICKS);
        settle_to_idle();

        // Directed: zero limits, stale echo, start while busy, minimal timeout.
        src_pct  = 0;
        sink_pct = 0;
        program_ranger(0, 0, 0);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b0, 1'b1);
        queue_tick(1'b1, 1'b1);
        queue_tick(1'b0, 1'b1);
        queue_tick(1'b0, 1'b1);
        queue_tick(1'b1, 1'b1);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b0, 1'b1);
        queue_tick(1'b0, 1'b1);
        queue_tick(1'b1, 1'b0);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b0, 1'b1);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b1, 1'b1);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b0, 1'b1);
        queue_tick(1'b1, 1'b1);
        settle_to_idle();

        // Random phases over a range of short settings and idling mixes.
        src_pct  = 30;
        sink_pct = 30;
        program_ranger(1, 1, 1);
        queue_random_ticks(PHASE_TICKS);
        settle_to_idle();

        src_pct  = 0;
        sink_pct = 40;
        program_ranger(4, 2, 12);
        queue_random_ticks(PHASE_TICKS);
        settle_to_idle();

        src_pct  = 25;
        sink_pct = 0;
        program_ranger(0, 7, 30);
        queue_random_ticks(PHASE_TICKS);
        settle_to_idle();

        src_pct  = 15;
        sink_pct = 15;
        program_ranger($urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 25));
        queue_random_ticks(PHASE_TICKS);
        settle_to_idle();

        // Longer limits: one full measurement running into the timeout.
        src_pct  = 0;
        sink_pct = 0;
        program_ranger(24, 16, 40);
        queue_tick(1'b1, 1'b0);
        repeat (45) queue_tick(1'b0, 1'b0);
        repeat (42) queue_tick(1'b0, 1'b1);
        repeat (3) queue_tick(1'b0, 1'b0);
        settle_to_idle();

        // Final stretch without idling.
        program_ranger($urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 25));
        queue_random_ticks(PHASE_TICKS);
        wait_drained();
        repeat (4) @(posedge aclk);

        if (expected_readings.size() != 0) begin
            flag_error($sformatf("%0d results never arrived", expected_readings.size()));
        end
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
